>>> design/mgm_pkg.sv
`timescale 1ns / 1ps

package mgm_pkg;

  // Sources and destinations carried on the ports.
  localparam int NUM_LANES = 4;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int FRAC_BITS = 14;

  // (gd*gs)>>14 spans [-65536, 65536], cell gain spans [-131072, 131072],
  // and one term spans [-262144, 262144].
  localparam int STAGE1_W = 18;
  localparam int CELL_W   = 19;
  localparam int TERM_W   = 20;
  // Destination value plus four terms.
  localparam int ACC_W    = 22;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int ROUTE_W    = 16;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] REG_DEST_GAINS = 2'd0;
  localparam logic [1:0] REG_SRC_GAINS  = 2'd1;
  localparam logic [1:0] REG_CHAN_GAINS = 2'd2;
  localparam logic [1:0] REG_ROUTE_EN   = 2'd3;

  // Cycles the cell gain registers need after a register write.
  localparam logic [1:0] CFG_SETTLE = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  localparam acc_t SAT_MAX = acc_t'(32767);
  localparam acc_t SAT_MIN = -acc_t'(32768);

  typedef struct packed {
    logic [CFG_DATA_W-1:0] dest_gains;
    logic [CFG_DATA_W-1:0] src_gains;
    logic [CFG_DATA_W-1:0] chan_gains;
    logic [ROUTE_W-1:0]    route_en;
  } cfg_t;

  typedef struct packed {
    logic                          valid;
    logic                          block_end;
    logic [NUM_LANES-1:0][SAMPLE_W-1:0] sample;
    logic [NUM_LANES-1:0][ACC_W-1:0]    acc;
  } chain_t;

endpackage

>>> design/mgm_cfg.sv
`timescale 1ns / 1ps

module mgm_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mgm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [mgm_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [mgm_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output mgm_pkg::cfg_t                   cfg,
  output logic                            busy
);
  import mgm_pkg::*;

  logic [CFG_DATA_W-1:0] dest_gains_r, dest_gains_nxt;
  logic [CFG_DATA_W-1:0] src_gains_r, src_gains_nxt;
  logic [CFG_DATA_W-1:0] chan_gains_r, chan_gains_nxt;
  logic [ROUTE_W-1:0]    route_en_r, route_en_nxt;
  logic [1:0]            hold_r, hold_nxt;
  logic                  wr_en;
  logic [1:0]            reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:3];

  always_comb begin
    dest_gains_nxt = dest_gains_r;
    src_gains_nxt  = src_gains_r;
    chan_gains_nxt = chan_gains_r;
    route_en_nxt   = route_en_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_DEST_GAINS: dest_gains_nxt = pwdata;
        REG_SRC_GAINS:  src_gains_nxt  = pwdata;
        REG_CHAN_GAINS: chan_gains_nxt = pwdata;
        REG_ROUTE_EN:   route_en_nxt   = pwdata[ROUTE_W-1:0];
      endcase
    end
  end

  // The cells rebuild their gain products through stage1_r and cell_gain_r after a write.
  always_comb begin
    hold_nxt = hold_r;
    if (wr_en) begin
      hold_nxt = CFG_SETTLE;
    end else if (hold_r != 2'd0) begin
      hold_nxt = hold_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_gains_r <= '0;
      src_gains_r  <= '0;
      chan_gains_r <= '0;
      route_en_r   <= '0;
      hold_r       <= CFG_SETTLE;
    end else begin
      dest_gains_r <= dest_gains_nxt;
      src_gains_r  <= src_gains_nxt;
      chan_gains_r <= chan_gains_nxt;
      route_en_r   <= route_en_nxt;
      hold_r       <= hold_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEST_GAINS: prdata = dest_gains_r;
      REG_SRC_GAINS:  prdata = src_gains_r;
      REG_CHAN_GAINS: prdata = chan_gains_r;
      REG_ROUTE_EN:   prdata = {{(CFG_DATA_W-ROUTE_W){1'b0}}, route_en_r};
    endcase
  end

  assign busy = (hold_r != 2'd0);

  always_comb begin
    cfg.dest_gains = dest_gains_r;
    cfg.src_gains  = src_gains_r;
    cfg.chan_gains = chan_gains_r;
    cfg.route_en   = route_en_r;
  end

  a_busy_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> busy) else $error("busy low right after a register write");

  a_busy_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ##2 busy) else $error("busy dropped before cell gains settled");

endmodule

>>> design/mgm_cell.sv
`timescale 1ns / 1ps

module mgm_cell #(
  parameter int CELL_IDX   = 0,
  parameter int DEST_COUNT = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mgm_pkg::cfg_t   cfg,
  input  mgm_pkg::chain_t chain_in,
  output mgm_pkg::chain_t chain_out
);
  import mgm_pkg::*;

  localparam int P1_W = 2 * GAIN_W;
  localparam int P2_W = STAGE1_W + GAIN_W;
  localparam int P3_W = SAMPLE_W + CELL_W;

  logic signed [GAIN_W-1:0]   src_gain;
  logic signed [GAIN_W-1:0]   chan_gain;
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [GAIN_W-1:0]   dest_gain     [NUM_LANES];
  logic signed [P1_W-1:0]     prod1         [NUM_LANES];
  logic signed [P2_W-1:0]     prod2         [NUM_LANES];
  logic signed [P3_W-1:0]     prod3         [NUM_LANES];
  logic signed [STAGE1_W-1:0] stage1_r      [NUM_LANES];
  logic signed [STAGE1_W-1:0] stage1_nxt    [NUM_LANES];
  logic signed [CELL_W-1:0]   cell_gain_r   [NUM_LANES];
  logic signed [CELL_W-1:0]   cell_gain_nxt [NUM_LANES];
  logic signed [TERM_W-1:0]   term          [NUM_LANES];
  chain_t                     data_nxt;
  chain_t                     data_r;
  logic                       valid_r;

  // Cell gains depend on the registers only, so they are built ahead of
  // time in two registered multiply steps.
  always_comb begin
    src_gain  = $signed(cfg.src_gains[GAIN_W*CELL_IDX +: GAIN_W]);
    chan_gain = $signed(cfg.chan_gains[GAIN_W*CELL_IDX +: GAIN_W]);
    sample    = $signed(chain_in.sample[CELL_IDX]);
    for (int d = 0; d < NUM_LANES; d++) begin
      dest_gain[d]     = $signed(cfg.dest_gains[GAIN_W*d +: GAIN_W]);
      prod1[d]         = dest_gain[d] * src_gain;
      stage1_nxt[d]    = $signed(prod1[d][FRAC_BITS+STAGE1_W-1:FRAC_BITS]);
      prod2[d]         = stage1_r[d] * chan_gain;
      cell_gain_nxt[d] = $signed(prod2[d][FRAC_BITS+CELL_W-1:FRAC_BITS]);
      prod3[d]         = sample * cell_gain_r[d];
      term[d]          = $signed(prod3[d][FRAC_BITS+TERM_W-1:FRAC_BITS]);
    end
  end

  always_comb begin
    data_nxt = chain_in;
    for (int d = 0; d < NUM_LANES; d++) begin
      if ((d < DEST_COUNT) && cfg.route_en[NUM_LANES*d+CELL_IDX]) begin
        data_nxt.acc[d] = $signed(chain_in.acc[d]) + ACC_W'(term[d]);
      end
    end
  end

  always_ff @(posedge clk) begin
    stage1_r    <= stage1_nxt;
    cell_gain_r <= cell_gain_nxt;
    data_r      <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= chain_in.valid;
    end
  end

  always_comb begin
    chain_out       = data_r;
    chain_out.valid = valid_r;
  end

  a_samples_pass: assert property (@(posedge clk) disable iff (!rst_n)
    chain_in.valid |=> chain_out.sample == $past(chain_in.sample))
    else $error("sample vector changed inside a cell");

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_chk
    a_unrouted_pass: assert property (@(posedge clk) disable iff (!rst_n)
      (chain_in.valid && !((g < DEST_COUNT) && cfg.route_en[NUM_LANES*g+CELL_IDX]))
      |=> chain_out.acc[g] == $past(chain_in.acc[g]))
      else $error("unrouted destination sum was modified");
  end

endmodule

>>> design/modulation_gain_matrix.sv
`timescale 1ns / 1ps

// A request passes each source cell, adding its terms, then the output register.
// Throughput: one request per cycle while busy is low; the receiver cannot stall.
// busy is high during reset and after it, and after each register write, until the
// counter loaded with CFG_SETTLE runs out while the cells rebuild gain products.
// Config and valid registers reset to zero; out_valid lasts one cycle.
module modulation_gain_matrix #(
  parameter int SOURCE_COUNT = 4,
  parameter int DEST_COUNT   = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  mgm_pkg::sample_t                in_src_sample_0,
  input  mgm_pkg::sample_t                in_src_sample_1,
  input  mgm_pkg::sample_t                in_src_sample_2,
  input  mgm_pkg::sample_t                in_src_sample_3,
  input  mgm_pkg::sample_t                in_dest_value_0,
  input  mgm_pkg::sample_t                in_dest_value_1,
  input  mgm_pkg::sample_t                in_dest_value_2,
  input  mgm_pkg::sample_t                in_dest_value_3,
  input  logic                            in_block_end_in,
  output logic                            out_valid,
  output mgm_pkg::sample_t                out_dest_out_0,
  output mgm_pkg::sample_t                out_dest_out_1,
  output mgm_pkg::sample_t                out_dest_out_2,
  output mgm_pkg::sample_t                out_dest_out_3,
  output logic                            out_block_end_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mgm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [mgm_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [mgm_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import mgm_pkg::*;

  cfg_t    cfg;
  chain_t  chain [SOURCE_COUNT+1];
  acc_t    final_acc   [NUM_LANES];
  sample_t out_dest_nxt[NUM_LANES];
  sample_t out_dest_r  [NUM_LANES];
  logic    out_end_r;
  logic    out_valid_r;

  mgm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .busy    (busy)
  );

  // Head of the chain: each destination sum starts at its current value.
  always_comb begin
    chain[0].valid     = start && !busy;
    chain[0].block_end = in_block_end_in;
    chain[0].sample[0] = in_src_sample_0;
    chain[0].sample[1] = in_src_sample_1;
    chain[0].sample[2] = in_src_sample_2;
    chain[0].sample[3] = in_src_sample_3;
    chain[0].acc[0]    = ACC_W'(in_dest_value_0);
    chain[0].acc[1]    = ACC_W'(in_dest_value_1);
    chain[0].acc[2]    = ACC_W'(in_dest_value_2);
    chain[0].acc[3]    = ACC_W'(in_dest_value_3);
  end

  for (genvar g = 0; g < SOURCE_COUNT; g++) begin : g_cell
    mgm_cell #(
      .CELL_IDX   (g),
      .DEST_COUNT (DEST_COUNT)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg       (cfg),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1])
    );
  end

  always_comb begin
    for (int d = 0; d < NUM_LANES; d++) begin
      final_acc[d] = $signed(chain[SOURCE_COUNT].acc[d]);
      if (final_acc[d] > SAT_MAX) begin
        out_dest_nxt[d] = SAMPLE_W'(SAT_MAX);
      end else if (final_acc[d] < SAT_MIN) begin
        out_dest_nxt[d] = SAMPLE_W'(SAT_MIN);
      end else begin
        out_dest_nxt[d] = SAMPLE_W'(final_acc[d]);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_dest_r <= out_dest_nxt;
    out_end_r  <= chain[SOURCE_COUNT].block_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[SOURCE_COUNT].valid;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_dest_out_0    = out_dest_r[0];
  assign out_dest_out_1    = out_dest_r[1];
  assign out_dest_out_2    = out_dest_r[2];
  assign out_dest_out_3    = out_dest_r[3];
  assign out_block_end_out = out_end_r;

endmodule

>>> dv/tb_modulation_gain_matrix.sv
`timescale 1ns / 1ps

module tb_modulation_gain_matrix;
  import mgm_pkg::*;

  localparam int SRC_N = 4;
  localparam int DST_N = 4;
  localparam int CLK_PERIOD = 10;
  // Depth of the chain of source cells and the output register.
  localparam int PIPE_DEPTH = SRC_N + 1;

  typedef struct packed {
    logic                               block_end;
    logic [NUM_LANES-1:0][SAMPLE_W-1:0] src;
    logic [NUM_LANES-1:0][SAMPLE_W-1:0] dest;
  } mix_request_t;

  typedef struct packed {
    logic                               block_end;
    logic [NUM_LANES-1:0][SAMPLE_W-1:0] dest;
  } mix_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  sample_t               drv_src [NUM_LANES];
  sample_t               drv_dest [NUM_LANES];
  logic                  drv_block_end;
  logic                  out_valid;
  sample_t               got_dest [NUM_LANES];
  logic                  got_block_end;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  cfg_t        gain_regs;
  mix_result_t mix_expected_q[$];
  mix_result_t due_result;
  int          mismatch_count = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  modulation_gain_matrix #(
    .SOURCE_COUNT(SRC_N),
    .DEST_COUNT  (DST_N)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_src_sample_0  (drv_src[0]),
    .in_src_sample_1  (drv_src[1]),
    .in_src_sample_2  (drv_src[2]),
    .in_src_sample_3  (drv_src[3]),
    .in_dest_value_0  (drv_dest[0]),
    .in_dest_value_1  (drv_dest[1]),
    .in_dest_value_2  (drv_dest[2]),
    .in_dest_value_3  (drv_dest[3]),
    .in_block_end_in  (drv_block_end),
    .out_valid        (out_valid),
    .out_dest_out_0   (got_dest[0]),
    .out_dest_out_1   (got_dest[1]),
    .out_dest_out_2   (got_dest[2]),
    .out_dest_out_3   (got_dest[3]),
    .out_block_end_out(got_block_end),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  task automatic report_mismatch(input string msg);
    // Printing stops after a while so a broken block cannot flood the log.
    if (mismatch_count < 100) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  function automatic mix_result_t predict_mix(input mix_request_t req);
    mix_result_t res;
    longint      acc;
    longint      gd;
    longint      cell_gain;
    for (int d = 0; d < NUM_LANES; d++) begin
      acc = longint'(sample_t'(req.dest[d]));
      if (d < DST_N) begin
        gd = longint'(sample_t'(gain_regs.dest_gains[16*d +: 16]));
        for (int s = 0; s < NUM_LANES && s < SRC_N; s++) begin
          if (gain_regs.route_en[4*d + s]) begin
            cell_gain = (gd * longint'(sample_t'(gain_regs.src_gains[16*s +: 16])))
                        >>> FRAC_BITS;
            cell_gain = (cell_gain * longint'(sample_t'(gain_regs.chan_gains[16*s +: 16])))
                        >>> FRAC_BITS;
            acc += (longint'(sample_t'(req.src[s])) * cell_gain) >>> FRAC_BITS;
          end
        end
      end
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      res.dest[d] = acc[15:0];
    end
    res.block_end = req.block_end;
    return res;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] reg_value(input logic [1:0] idx);
    case (idx)
      REG_DEST_GAINS: return gain_regs.dest_gains;
      REG_SRC_GAINS:  return gain_regs.src_gains;
      REG_CHAN_GAINS: return gain_regs.chan_gains;
      default:        return {{(CFG_DATA_W-ROUTE_W){1'b0}}, gain_regs.route_en};
    endcase
  endfunction

  // Writes one register through the APB port, then reads it back.
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_ADDR_W-1:0] addr;
    addr = {idx, 3'b000};
    while (busy) @(negedge clk);
    case (idx)
      REG_DEST_GAINS: gain_regs.dest_gains = value;
      REG_SRC_GAINS:  gain_regs.src_gains = value;
      REG_CHAN_GAINS: gain_regs.chan_gains = value;
      default:        gain_regs.route_en = value[ROUTE_W-1:0];
    endcase
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = addr;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    pwdata = '0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== reg_value(idx)) begin
      report_mismatch($sformatf("register %0d read %h, expected %h",
                                idx, prdata, reg_value(idx)));
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_all_regs(input logic [CFG_DATA_W-1:0] dg, input logic [CFG_DATA_W-1:0] sg,
                                input logic [CFG_DATA_W-1:0] cg, input logic [ROUTE_W-1:0] route);
    write_reg(REG_DEST_GAINS, dg);
    write_reg(REG_SRC_GAINS, sg);
    write_reg(REG_CHAN_GAINS, cg);
    write_reg(REG_ROUTE_EN, {{(CFG_DATA_W-ROUTE_W){1'b0}}, route});
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_mix(input mix_request_t req);
    for (int i = 0; i < NUM_LANES; i++) begin
      drv_src[i] = req.src[i];
      drv_dest[i] = req.dest[i];
    end
    drv_block_end = req.block_end;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    mix_expected_q.push_back(predict_mix(req));
    @(negedge clk);
  endtask

  // The payload carries junk while start is low.
  task automatic idle_gap(input int cycles);
    for (int n = 0; n < cycles; n++) begin
      start = 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
        drv_src[i] = sample_t'($urandom);
        drv_dest[i] = sample_t'($urandom);
      end
      drv_block_end = 1'($urandom_range(0, 1));
      @(negedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic mix_request_t random_request();
    mix_request_t req;
    for (int i = 0; i < NUM_LANES; i++) begin
      req.src[i] = random_sample();
      req.dest[i] = random_sample();
    end
    req.block_end = ($urandom_range(0, 7) == 0);
    return req;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_gains();
    logic [CFG_DATA_W-1:0] g;
    g = {$urandom, $urandom};
    // Gains near unity keep many sums out of saturation.
    if ($urandom_range(0, 1) == 1) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        g[16*i +: 16] = 16'($signed($urandom_range(0, 40000)) - 20000);
      end
    end
    return g;
  endfunction

  task automatic wait_for_results();
    start = 1'b0;
    while (mix_expected_q.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  task automatic send_directed(input logic [63:0] src, input logic [63:0] dest, input logic be);
    send_mix({be, src, dest});
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (mix_expected_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        due_result = mix_expected_q.pop_front();
        for (int d = 0; d < NUM_LANES; d++) begin
          if (got_dest[d] !== sample_t'(due_result.dest[d])) begin
            report_mismatch($sformatf("dest_out_%0d is %0d, expected %0d", d,
                                      got_dest[d], sample_t'(due_result.dest[d])));
          end
        end
        if (got_block_end !== due_result.block_end) begin
          report_mismatch($sformatf("block_end_out is %b, expected %b",
                                    got_block_end, due_result.block_end));
        end
      end
    end
  end

  // With every register at zero the destinations pass through untouched.
  task automatic test_reset_passthrough();
    send_directed(64'h7FFF_8000_0000_FFFF, 64'h8000_7FFF_FFFF_0000, 1'b1);
    send_directed(64'h1234_5678_9ABC_DEF0, 64'hFEDC_BA98_7654_3210, 1'b0);
    idle_gap(2);
    wait_for_results();
  endtask

  task automatic test_unity_extremes();
    write_all_regs(64'h4000_4000_4000_4000, 64'h4000_4000_4000_4000,
                   64'h4000_4000_4000_4000, 16'hFFFF);
    send_directed(64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF, 1'b1);
    send_directed(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, 1'b0);
    send_directed(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 1'b1);
    send_directed(64'hC000_4000_FFFF_0001, 64'h0000_0000_0000_0000, 1'b0);
    send_directed(64'h7FFF_8000_7FFF_8000, 64'h0100_FF00_8000_7FFF, 1'b0);
    wait_for_results();
  endtask

  // Routes with holes: a skipped source must not stop the later ones.
  // Negative gains invert the contribution.
  task automatic test_sparse_routes_negative_gains();
    write_all_regs(64'hC000_4000_2000_E000, 64'h4000_C000_4000_4000,
                   64'h4000_4000_8001_4000, 16'h8DB6);
    send_directed(64'h1000_2000_3000_4000, 64'h0000_0000_0000_0000, 1'b0);
    send_directed(64'hF000_E000_D000_C000, 64'h0100_0200_0300_0400, 1'b1);
    send_directed(64'h7FFF_0001_8000_FFFF, 64'h8000_7FFF_0000_FFFF, 1'b0);
    // The routing may only change once the chain has drained.
    wait_for_results();
    write_reg(REG_ROUTE_EN, 64'h0000_0000_0000_4182);
    send_directed(64'h2000_2000_2000_2000, 64'h0000_0000_0000_0000, 1'b1);
    send_directed(64'h8000_7FFF_8000_7FFF, 64'hFFFF_0001_FFFF_0001, 1'b0);
    wait_for_results();
  endtask

  task automatic test_extreme_gains();
    write_all_regs(64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF,
                   64'h7FFF_7FFF_7FFF_7FFF, 16'hFFFF);
    send_directed(64'h0001_0001_0001_0001, 64'h0000_0000_0000_0000, 1'b0);
    send_directed(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 1'b1);
    send_directed(64'h0400_FC00_0010_FFF0, 64'h7000_9000_0000_0000, 1'b0);
    wait_for_results();
    write_all_regs(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
                   64'h8000_8000_8000_8000, 16'hFFFF);
    send_directed(64'h0001_0001_0001_0001, 64'h0000_0000_0000_0000, 1'b1);
    send_directed(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000, 1'b0);
    send_directed(64'h0FFF_F001_0003_FFFD, 64'h1000_F000_0000_0000, 1'b0);
    wait_for_results();
  endtask

  task automatic test_random_mixing();
    logic [CFG_DATA_W-1:0] dg, sg, cg;
    logic [ROUTE_W-1:0]    route;
    for (int phase = 0; phase < 10; phase++) begin
      dg = random_gains();
      sg = random_gains();
      cg = random_gains();
      route = 16'($urandom);
      case (phase)
        0: begin
          dg = '1; sg = '1; cg = '1; route = '1;
        end
        1: begin
          dg = '0; route = '0;
        end
        2: route = '1;
        default: ;
      endcase
      write_all_regs(dg, sg, cg, route);
      for (int n = 0; n < 53; n++) begin
        send_mix(random_request());
        // Every fourth phase runs back to back.
        if (phase % 4 != 3) idle_gap(pick_gap());
      end
      wait_for_results();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      drv_src[i] = '0;
      drv_dest[i] = '0;
    end
    drv_block_end = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gain_regs = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_reset_passthrough();
    test_unity_extremes();
    test_sparse_routes_negative_gains();
    test_extreme_gains();
    test_random_mixing();

    wait_for_results();
    repeat (PIPE_DEPTH * 2) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("** modulation_gain_matrix: PASSED **");
    end else begin
      $display("** modulation_gain_matrix: FAILED **");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", mix_expected_q.size());
    $display("** modulation_gain_matrix: FAILED **");
    $finish;
  end

endmodule
